FILE: sv/tosa_pkg.sv
// Shared types and constants for the typed oldest-slot allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tosa_pkg;

	localparam int ENTRIES_DEF = 32;

	localparam int NOW_W      = 32;
	localparam int KIND_W     = 3;
	localparam int LIFE_W     = 16;
	localparam int SLOT_W     = 5;
	localparam int EXPD_W     = 6;
	localparam int LIVE_W     = 16;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 1;

	localparam logic [KIND_W-1:0]    KIND_UNUSED   = 3'd0;
	localparam logic [KIND_W-1:0]    KIND_MAX      = 3'd5;
	localparam logic [LIFE_W-1:0]    LIFETIME_RST  = 16'd120;
	localparam logic [NOW_W-1:0]     BOUND_RST     = 32'd9999999;
	localparam logic [LIVE_W-1:0]    LIVE_MAX      = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_LIFETIME  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND     = 1'd1;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SWEEP,
		OP_REJECT
	} op_t;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		op_t               op;
		logic [KIND_W-1:0] kind;
		logic [NOW_W-1:0]  now;
		logic [NOW_W-1:0]  expiry;
	} item_t;

	typedef struct packed {
		logic              accepted;
		logic [SLOT_W-1:0] slot;
		logic [EXPD_W-1:0] expired_now;
		logic [LIVE_W-1:0] live_count;
	} res_t;

endpackage

FILE: sv/tosa_front.sv
// Front end: accepts input beats, classifies them and forms the expiry time.
// Holds a two-entry queue toward the back end. Depends on tosa_pkg.
`timescale 1ns / 1ps

module tosa_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_mode,
	input  logic [tosa_pkg::KIND_W-1:0] in_kind,
	input  logic [tosa_pkg::NOW_W-1:0]  in_now,
	input  logic [tosa_pkg::LIFE_W-1:0] lifetime,
	output logic                     q_valid,
	output tosa_pkg::item_t          q_item,
	input  logic                     q_pop
);
	import tosa_pkg::*;

	localparam int QDEPTH = 2;

	item_t                        slots_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0]    wr_ptr_q;
	logic [$clog2(QDEPTH)-1:0]    rd_ptr_q;
	logic [$clog2(QDEPTH+1)-1:0]  count_q;
	item_t                        new_item;
	logic [NOW_W:0]               sum;
	logic                         push;
	logic                         pop;

	// Saturate the expiry at the top of the time range.
	assign sum = {1'b0, in_now} + {{(NOW_W+1-LIFE_W){1'b0}}, lifetime};

	always_comb begin
		new_item.kind   = in_kind;
		new_item.now    = in_now;
		new_item.expiry = sum[NOW_W] ? {NOW_W{1'b1}} : sum[NOW_W-1:0];
		priority if (in_mode)
			new_item.op = OP_SWEEP;
		else if (in_kind > KIND_MAX)
			new_item.op = OP_REJECT;
		else
			new_item.op = OP_ADD;
	end

	assign in_ready = (count_q != ($clog2(QDEPTH+1))'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: sv/tosa_back.sv
// Back end: scans the entry table one entry a cycle, then commits an add or a sweep
// and holds the result beat; a rejected item skips the scan. Depends on tosa_pkg.
`timescale 1ns / 1ps

module tosa_back #(
	parameter int ENTRIES = tosa_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  tosa_pkg::item_t           q_item,
	output logic                      q_pop,
	input  logic [tosa_pkg::NOW_W-1:0] bound,
	output logic                      out_valid,
	input  logic                      out_ready,
	output tosa_pkg::res_t            out_res
);
	import tosa_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t               state_q;
	item_t                item_q;

	// Table storage: kind and expiry in memory, written flags and live marks in flops.
	logic [KIND_W-1:0]    mem_kind [ENTRIES];
	logic [NOW_W-1:0]     mem_exp  [ENTRIES];
	logic [ENTRIES-1:0]   written_q;
	logic [ENTRIES-1:0]   live_q;
	logic [LIVE_W-1:0]    live_total_q;

	logic [CNT_W-1:0]     rd_cnt_q;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [KIND_W-1:0]    kind_s1;
	logic [NOW_W-1:0]     exp_raw_s1;
	logic                 written_s1;
	logic [KIND_W-1:0]    ent_kind;
	logic [NOW_W-1:0]     ent_exp;

	logic [NOW_W-1:0]     best_t_q;
	logic [NOW_W-1:0]     best_a_q;
	logic [IDX_W-1:0]     idx_t_q;
	logic [IDX_W-1:0]     idx_a_q;
	logic                 found_t_q;
	logic                 found_a_q;
	logic [CNT_W-1:0]     expired_q;

	logic                 out_free;
	logic [IDX_W-1:0]     pick;
	logic                 hit_t;
	logic                 hit_a;
	logic                 hit_sweep;

	assign out_free = !out_valid || out_ready;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign rd_en    = (state_q == ST_SCAN) && (rd_cnt_q != CNT_END);
	assign rd_addr  = rd_cnt_q[IDX_W-1:0];

	// An entry never written reads as its reset value.
	assign ent_kind = written_s1 ? kind_s1 : KIND_UNUSED;
	assign ent_exp  = written_s1 ? exp_raw_s1 : '0;

	assign hit_t = ((ent_kind == KIND_UNUSED) || (ent_kind == item_q.kind))
		&& (ent_exp < best_t_q);
	assign hit_a = (ent_exp < best_a_q);
	assign hit_sweep = live_q[idx_s1] && (ent_exp <= item_q.now);

	always_comb begin
		priority if ((item_q.kind != KIND_UNUSED) && found_t_q)
			pick = idx_t_q;
		else if (found_a_q)
			pick = idx_a_q;
		else
			pick = '0;
	end

	// Memory read port, registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			kind_s1    <= mem_kind[rd_addr];
			exp_raw_s1 <= mem_exp[rd_addr];
			written_s1 <= written_q[rd_addr];
			idx_s1     <= rd_addr;
		end
	end

	// Memory write port: commit of an add.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free && item_q.op == OP_ADD) begin
			mem_kind[pick] <= item_q.kind;
			mem_exp[pick]  <= item_q.expiry;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			item_q <= q_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			written_q    <= '0;
			live_q       <= '0;
			live_total_q <= '0;
			rd_cnt_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			best_t_q     <= '0;
			best_a_q     <= '0;
			idx_t_q      <= '0;
			idx_a_q      <= '0;
			found_t_q    <= 1'b0;
			found_a_q    <= 1'b0;
			expired_q    <= '0;
			out_valid    <= 1'b0;
			out_res      <= '0;
		end else begin
			// in ST_DONE a free output slot is refilled below
			if (out_valid && out_ready && (state_q != ST_DONE))
				out_valid <= 1'b0;
			cmp_vld_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						rd_cnt_q  <= '0;
						best_t_q  <= bound;
						best_a_q  <= bound;
						idx_t_q   <= '0;
						idx_a_q   <= '0;
						found_t_q <= 1'b0;
						found_a_q <= 1'b0;
						expired_q <= '0;
						state_q   <= (q_item.op == OP_REJECT) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en)
						rd_cnt_q <= rd_cnt_q + 1'b1;
					if (cmp_vld_s1) begin
						if (item_q.op == OP_ADD) begin
							if (hit_t) begin
								best_t_q  <= ent_exp;
								idx_t_q   <= idx_s1;
								found_t_q <= 1'b1;
							end
							if (hit_a) begin
								best_a_q  <= ent_exp;
								idx_a_q   <= idx_s1;
								found_a_q <= 1'b1;
							end
						end else if (hit_sweep) begin
							live_q[idx_s1] <= 1'b0;
							expired_q      <= expired_q + 1'b1;
							if (live_total_q != '0)
								live_total_q <= live_total_q - 1'b1;
						end
						if (idx_s1 == LAST_IDX)
							state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						out_res.expired_now <= EXPD_W'(32'(expired_q));
						if (item_q.op == OP_ADD) begin
							written_q[pick]    <= 1'b1;
							live_q[pick]       <= 1'b1;
							out_res.accepted   <= 1'b1;
							out_res.slot       <= SLOT_W'(32'(pick));
							if (live_total_q != LIVE_MAX) begin
								live_total_q       <= live_total_q + 1'b1;
								out_res.live_count <= live_total_q + 1'b1;
							end else begin
								out_res.live_count <= live_total_q;
							end
						end else begin
							out_res.accepted   <= 1'b0;
							out_res.slot       <= '0;
							out_res.live_count <= live_total_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/typed_oldest_slot_allocator_unit.sv
// Typed oldest-slot allocator: for an add or a sweep the back end scans the entry
// table through one memory read port, one entry per cycle; a rejected kind skips the
// scan. The back end finishes one item before it takes the next, while the front
// queues up to two further beats. Reset (arst_n low, async) empties the table at once
// through per-entry flags, zeroes the live count and loads lifetime 120 and search
// start bound 9999999. No clearing pass is needed.
`timescale 1ns / 1ps

module typed_oldest_slot_allocator_unit #(
	parameter int ENTRIES = tosa_pkg::ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [tosa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tosa_pkg::CFG_W-1:0]        cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,   // [31:0] now
	input  logic [3:0]                        s_tuser,   // [0] mode, [3:1] kind
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,   // [4:0] slot, [10:5] expired_now,
	                                                     // [26:11] live_count, [31:27] zero
	output logic                              m_tuser    // [0] accepted
);
	import tosa_pkg::*;

	logic [LIFE_W-1:0] lifetime_q;
	logic [NOW_W-1:0]  bound_q;
	logic              q_valid;
	logic              q_pop;
	item_t             q_item;
	res_t              res;

	// Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RST;
			bound_q    <= BOUND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LIFETIME: lifetime_q <= cfg_data[LIFE_W-1:0];
				REG_BOUND:    bound_q    <= cfg_data[NOW_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: accept and classify each beat, queue it for the back end.
	tosa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_mode  (s_tuser[0]),
		.in_kind  (s_tuser[3:1]),
		.in_now   (s_tdata),
		.lifetime (lifetime_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// Back: scan the table, commit the add or sweep, hold the result beat.
	tosa_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.bound     (bound_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// Pack the result beat.
	assign m_tdata = {5'd0, res.live_count, res.expired_now, res.slot};
	assign m_tuser = res.accepted;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for typed_oldest_slot_allocator_unit: directed and random
// add/sweep beats, an in-bench slot predictor and a result checker. Needs tosa_pkg.
`timescale 1ns / 1ps

module tb_top;
	import tosa_pkg::*;

	localparam int          ENTRIES    = ENTRIES_DEF;
	localparam int          CLK_HALF   = 6;
	localparam int unsigned CYCLE_CAP  = 600000;
	localparam logic        MODE_ADD   = 1'b0;
	localparam logic        MODE_SWEEP = 1'b1;
	// add beats with kinds above KIND_MAX are turned away by the block
	localparam logic [KIND_W-1:0] KIND_REJ_LO = KIND_MAX + 1'b1;
	localparam logic [KIND_W-1:0] KIND_REJ_HI = '1;
	localparam logic [NOW_W-1:0]  NOW_TOP     = '1;

	// Tracks the entry table and predicts every result beat, oldest first.
	class slot_grant_tracker;
		logic [KIND_W-1:0] kinds [ENTRIES];
		logic [NOW_W-1:0]  expiry [ENTRIES];
		logic              live [ENTRIES];
		logic [LIVE_W-1:0] live_total;
		logic [LIFE_W-1:0] lifetime;
		logic [NOW_W-1:0]  bound;
		res_t              grants[$];
		int unsigned       mismatches;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				kinds[i] = KIND_UNUSED;
				expiry[i] = '0;
				live[i] = 1'b0;
			end
			live_total = '0;
			lifetime = LIFETIME_RST;
			bound = BOUND_RST;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_LIFETIME)
				lifetime = data[LIFE_W-1:0];
			else if (idx == REG_BOUND)
				bound = data[NOW_W-1:0];
		endfunction

		// Oldest matching entry first, then oldest overall; only expiries under bound count.
		function int unsigned choose_slot(logic [KIND_W-1:0] k);
			logic [NOW_W-1:0] best;
			int unsigned      idx;
			bit               hit;
			idx = 0;
			hit = 0;
			if (k != KIND_UNUSED) begin
				best = bound;
				for (int i = 0; i < ENTRIES; i++) begin
					if (expiry[i] < best && (kinds[i] == KIND_UNUSED || kinds[i] == k)) begin
						best = expiry[i];
						idx = i;
						hit = 1;
					end
				end
				if (hit)
					return idx;
			end
			best = bound;
			for (int i = 0; i < ENTRIES; i++) begin
				if (expiry[i] < best) begin
					best = expiry[i];
					idx = i;
				end
			end
			return idx;
		endfunction

		function void note_request(logic mode, logic [KIND_W-1:0] k, logic [NOW_W-1:0] now);
			res_t            r;
			logic [NOW_W:0]  sum;
			int unsigned     s;
			int unsigned     cleared;
			r = '0;
			cleared = 0;
			if (mode == MODE_ADD) begin
				if (k <= KIND_MAX) begin
					sum = {1'b0, now} + lifetime;
					s = choose_slot(k);
					kinds[s] = k;
					expiry[s] = sum[NOW_W] ? NOW_TOP : sum[NOW_W-1:0];
					live[s] = 1'b1;
					// overwriting a live entry still counts as a new one
					if (live_total != LIVE_MAX)
						live_total++;
					r.accepted = 1'b1;
					r.slot = s[SLOT_W-1:0];
				end
			end else begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (live[i] && expiry[i] <= now) begin
						live[i] = 1'b0;
						cleared++;
						if (live_total != '0)
							live_total--;
					end
				end
				r.expired_now = cleared[EXPD_W-1:0];
			end
			r.live_count = live_total;
			grants.push_back(r);
		endfunction

		function void check_grant(res_t got);
			res_t want;
			if (grants.size() == 0) begin
				$error("result beat with nothing expected: slot %0d live_count %0d",
					got.slot, got.live_count);
				mismatches++;
				return;
			end
			want = grants.pop_front();
			if (got.accepted !== want.accepted) begin
				$error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
				mismatches++;
			end
			if (got.slot !== want.slot) begin
				$error("slot: expected %0d, actual %0d", want.slot, got.slot);
				mismatches++;
			end
			if (got.expired_now !== want.expired_now) begin
				$error("expired_now: expected %0d, actual %0d", want.expired_now, got.expired_now);
				mismatches++;
			end
			if (got.live_count !== want.live_count) begin
				$error("live_count: expected %0d, actual %0d", want.live_count, got.live_count);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return grants.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata = '0;   // [31:0] now
	logic [3:0]           s_tuser = '0;   // [0] mode, [3:1] kind
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;        // [4:0] slot, [10:5] expired_now, [26:11] live_count
	logic                 m_tuser;        // [0] accepted

	slot_grant_tracker tracker = new();

	// sender pacing: bursts of back-to-back beats, most separated by idle gaps
	int unsigned      burst_left = 1;
	bit               offering = 0;
	logic [NOW_W-1:0] time_base = '0;
	int unsigned      cycle_count = 0;

	typed_oldest_slot_allocator_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever begin
			#(CLK_HALF) clk = ~clk;
		end
	end

	// Offer one beat, hold it until the block takes it, then maybe idle.
	task automatic send_request(logic mode, logic [KIND_W-1:0] k, logic [NOW_W-1:0] now);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata <= now;
		s_tuser <= {k, mode};
		offering = 1;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.note_request(mode, k, now);
		burst_left--;
		if (burst_left == 0) begin
			// mostly short bursts, now and then a long unbroken run
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				offering = 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop the offer and wait until every predicted beat has come back.
	task automatic drain();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 0;
		end
		while (tracker.outstanding() != 0)
			@(posedge clk);
	endtask

	// One write cycle, then the enable is dropped before the next write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, data);
		@(posedge clk);
	endtask

	// Random traffic around a moving time base; step_max sets how fast time runs.
	task automatic random_phase(int unsigned count, int unsigned step_max);
		int unsigned       pick;
		logic [KIND_W-1:0] k;
		logic [NOW_W-1:0]  reach;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			time_base += $urandom_range(0, step_max);
			if (pick < 58) begin
				k = KIND_W'($urandom_range(1, KIND_MAX));
				send_request(MODE_ADD, k, time_base);
			end else if (pick < 68) begin
				send_request(MODE_ADD, KIND_UNUSED, time_base);
			end else if (pick < 74) begin
				k = KIND_W'($urandom_range(KIND_REJ_LO, KIND_REJ_HI));
				send_request(MODE_ADD, k, time_base);
			end else if (pick < 93) begin
				// sweep a little ahead so some entries fall due
				reach = time_base + $urandom_range(0, tracker.lifetime + step_max);
				k = KIND_W'($urandom);
				send_request(MODE_SWEEP, k, reach);
			end else begin
				k = KIND_W'($urandom);
				send_request(1'($urandom), k, $urandom);
			end
		end
	endtask

	// Result side: stall on a changing bit pattern, and hold off for a long
	// stretch now and then so the block backs up into its input.
	initial begin : result_sink
		int unsigned delivered;
		int unsigned hold_left;
		int unsigned next_hold_at;
		int unsigned pace;
		logic [15:0] ready_bits;
		delivered = 0;
		hold_left = 0;
		next_hold_at = 300;
		pace = 0;
		ready_bits = '1;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				delivered++;
			if (hold_left == 0 && delivered >= next_hold_at) begin
				hold_left = 500;
				next_hold_at += 700;
			end
			if (pace % 50 == 0)
				ready_bits = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
			pace++;
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ready_bits[pace % 16];
			end
		end
	end

	// Compare every result beat against the oldest prediction.
	always @(posedge clk) begin
		res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.accepted = m_tuser;
			got.slot = m_tdata[SLOT_W-1:0];
			got.expired_now = m_tdata[SLOT_W +: EXPD_W];
			got.live_count = m_tdata[SLOT_W+EXPD_W +: LIVE_W];
			tracker.check_grant(got);
		end
	end

	// Watchdog: give up on a hung block.
	initial begin : watchdog
		while (cycle_count < CYCLE_CAP) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at the reset settings: lifetime 120, bound 9999999.
		send_request(MODE_ADD, KIND_UNUSED, 32'd0);
		send_request(MODE_ADD, 3'd5, 32'd100);
		send_request(MODE_ADD, 3'd3, NOW_TOP);          // expiry saturates
		send_request(MODE_ADD, KIND_REJ_LO, 32'd10);    // rejected kind
		send_request(MODE_ADD, KIND_REJ_HI, NOW_TOP);   // rejected kind
		send_request(MODE_ADD, 3'd1, 32'd200);
		send_request(MODE_ADD, 3'd2, 32'd200);
		send_request(MODE_ADD, 3'd4, 32'd200);
		send_request(MODE_ADD, 3'd5, 32'd200);
		send_request(MODE_SWEEP, KIND_REJ_HI, 32'd99);
		send_request(MODE_SWEEP, KIND_UNUSED, 32'd220);
		// expiry right at the bound never qualifies, one below it does
		send_request(MODE_ADD, KIND_UNUSED, BOUND_RST - LIFETIME_RST);
		send_request(MODE_ADD, KIND_UNUSED, BOUND_RST - LIFETIME_RST - 1);
		send_request(MODE_ADD, 3'd5, 32'd300);
		send_request(MODE_ADD, 3'd5, 32'd300);
		send_request(MODE_SWEEP, 3'd0, NOW_TOP);
		send_request(MODE_SWEEP, 3'd0, 32'd0);
		send_request(MODE_ADD, 3'd2, 32'h5555_5555);
		send_request(MODE_ADD, 3'd1, 32'hAAAA_AAAA);
		send_request(MODE_SWEEP, 3'd5, 32'hAAAA_AAAA);
		send_request(MODE_ADD, 3'd1, 32'd400);

		// Lifetime of one, widest bound.
		drain();
		write_reg(REG_LIFETIME, 32'd1);
		write_reg(REG_BOUND, {CFG_W{1'b1}});
		time_base = 32'd50;
		random_phase(250, 3);

		// Longest lifetime, zero bound: nothing qualifies, slot 0 every time.
		drain();
		write_reg(REG_LIFETIME, 32'd65535);
		write_reg(REG_BOUND, 32'd0);
		time_base = 32'd1000;
		random_phase(150, 5000);

		// Zero lifetime: expiry equals now; tight bound.
		drain();
		write_reg(REG_LIFETIME, 32'd0);
		write_reg(REG_BOUND, 32'd203000);
		time_base = 32'd200000;
		random_phase(250, 20);

		// Random lifetime and bound near the working times.
		drain();
		time_base = 32'd5000;
		write_reg(REG_LIFETIME, $urandom_range(10, 500));
		write_reg(REG_BOUND, time_base + $urandom_range(2000, 8000));
		random_phase(300, 30);

		// Times close to the top so expiries saturate, then wrap.
		drain();
		write_reg(REG_LIFETIME, 32'd65535);
		write_reg(REG_BOUND, {CFG_W{1'b1}});
		time_base = NOW_TOP - 32'd150000;
		random_phase(200, 2000);

		// Back to the reset settings.
		drain();
		write_reg(REG_LIFETIME, LIFETIME_RST);
		write_reg(REG_BOUND, BOUND_RST);
		time_base = BOUND_RST - 32'd1500;
		random_phase(350, 10);

		drain();
		repeat (4 * ENTRIES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
